FILE: rtl/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    // Dividend is |a| << (FRAC_BITS + 1) plus |b|, one bit per divider step.
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS + 1;
    localparam int DIV_STEPS = NUM_BITS;
    localparam int DEN_BITS  = WORD_BITS + 1;
    localparam int PROD_BITS = WORD_BITS + FRAC_BITS;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_MIN      = 4'd4;
    localparam logic [3:0] OP_MAX      = 4'd5;
    localparam logic [3:0] OP_INC      = 4'd6;
    localparam logic [3:0] OP_DEC      = 4'd7;
    localparam logic [3:0] OP_TO_INT   = 4'd8;
    localparam logic [3:0] OP_FROM_INT = 4'd9;

    typedef struct packed {
        logic [3:0]                  operation;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_value;
        logic                        a_less_b;
        logic                        a_equal_b;
        logic                        a_greater_b;
        logic                        divide_by_zero;
    } out_word_t;

    // Word after classification in the front end.
    typedef struct packed {
        logic [3:0]                  operation;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
        logic                        less;
        logic                        equal;
        logic                        greater;
    } cls_word_t;

endpackage

`default_nettype wire

FILE: rtl/fixed_point_q24_8_alu.sv
// Signed Q24.8 ALU: push an operation word, pop a result word.
// Path: queue, execute register, 41-step pipelined divider, output register.
// Throughput: one word per cycle while no result waits unpopped at the output.
// All operations take the same path, so results leave in push order.
// Reset (rst_n, asynchronous) empties the queue and the pipeline at once.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_q24_8_alu (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  fpa_pkg::in_word_t   item,
    output logic                empty,
    input  wire                 pop,
    output fpa_pkg::out_word_t  result
);

    logic                head_valid;
    logic                head_pop;
    fpa_pkg::cls_word_t  head;

    fpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    fpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

FILE: rtl/fpa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fpa_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    output logic                  full,
    input  fpa_pkg::in_word_t     item,
    output logic                  head_valid,
    output fpa_pkg::cls_word_t    head,
    input  wire                   head_pop
);

    fpa_pkg::cls_word_t                  entry_reg [fpa_pkg::Q_DEPTH];
    logic [fpa_pkg::Q_PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [fpa_pkg::Q_PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [fpa_pkg::Q_CNT_W-1:0]         count_reg, count_next;
    fpa_pkg::cls_word_t                  cls;
    logic                                do_push;
    logic                                do_pop;

    function automatic logic [fpa_pkg::Q_CNT_W-1:0] Q_CNT_ONE(input logic v);
        return {{(fpa_pkg::Q_CNT_W-1){1'b0}}, v};
    endfunction

    always_comb
    begin
        cls.operation = item.operation;
        cls.operand_a = item.operand_a;
        cls.operand_b = item.operand_b;
        cls.less      = item.operand_a < item.operand_b;
        cls.equal     = item.operand_a == item.operand_b;
        cls.greater   = item.operand_a > item.operand_b;
    end

    assign full       = count_reg == fpa_pkg::Q_CNT_W'(fpa_pkg::Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_ONE(do_push) - Q_CNT_ONE(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fpa_pkg::Q_CNT_W'(fpa_pkg::Q_DEPTH))
        else $error("queue count above depth");
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[fpa_pkg::Q_PTR_W-1:0] == fpa_pkg::Q_PTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue count disagrees with pointers");
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> $onehot({head.less, head.equal, head.greater}))
        else $error("queued compare flags not one-hot");

endmodule

`default_nettype wire

FILE: rtl/fpa_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fpa_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   head_valid,
    input  fpa_pkg::cls_word_t    head,
    output logic                  head_pop,
    output logic                  empty,
    input  wire                   pop,
    output fpa_pkg::out_word_t    result
);

    localparam int W  = fpa_pkg::WORD_BITS;
    localparam int F  = fpa_pkg::FRAC_BITS;
    localparam int NB = fpa_pkg::NUM_BITS;
    localparam int DB = fpa_pkg::DEN_BITS;
    localparam int PB = fpa_pkg::PROD_BITS;
    localparam int NS = fpa_pkg::DIV_STEPS;

    typedef struct packed {
        logic          is_div;
        logic          is_mul;
        logic          neg;
        logic          dz;
        logic [NB-1:0] num;
        logic [DB-1:0] den;
        logic [PB-1:0] prod_lo;
        logic          prod_neg;
        logic [W-1:0]  res;
        logic          less;
        logic          equal;
        logic          greater;
    } exe_t;

    typedef struct packed {
        logic          is_div;
        logic          neg;
        logic          dz;
        logic [DB-1:0] rem;
        logic [NB-1:0] num;
        logic [DB-1:0] den;
        logic [W-1:0]  quo;
        logic [W-1:0]  res;
        logic          less;
        logic          equal;
        logic          greater;
    } stage_t;

    function automatic stage_t div_step(input stage_t s);
        stage_t        o;
        logic [DB:0]   r;
        logic [DB+1:0] diff;
        logic          qbit;
        o    = s;
        r    = {s.rem, s.num[NB-1]};
        diff = {1'b0, r} - {2'b00, s.den};
        qbit = !diff[DB+1];
        o.rem = qbit ? diff[DB-1:0] : r[DB-1:0];
        o.num = {s.num[NB-2:0], 1'b0};
        o.quo = {s.quo[W-2:0], qbit};
        return o;
    endfunction

    logic                  adv;
    exe_t                  exe_next, exe_reg;
    logic                  exe_valid_reg;
    stage_t                stage_reg  [NS];
    stage_t                stage_next [NS];
    logic [NS-1:0]         svalid_reg;
    stage_t                first;
    logic                  out_valid_reg;
    fpa_pkg::out_word_t    out_reg, out_next;
    logic signed [2*W-1:0] prod;
    logic [W-1:0]          mag_a, mag_b;
    logic [PB-1:0]         pmag, pround;
    logic [W-1:0]          mul_mag;

    assign adv      = !out_valid_reg || pop;
    assign head_pop = adv && head_valid;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // Execute stage: simple operations, the multiply, and divider operands.
    always_comb
    begin
        mag_a = head.operand_a[W-1] ? W'(0) - head.operand_a : head.operand_a;
        mag_b = head.operand_b[W-1] ? W'(0) - head.operand_b : head.operand_b;
        prod  = head.operand_a * head.operand_b;
        exe_next.is_div   = head.operation == fpa_pkg::OP_DIV;
        exe_next.is_mul   = head.operation == fpa_pkg::OP_MUL;
        exe_next.neg      = head.operand_a[W-1] ^ head.operand_b[W-1];
        exe_next.dz       = (head.operation == fpa_pkg::OP_DIV) && (head.operand_b == '0);
        exe_next.num      = {mag_a, {(F+1){1'b0}}} + NB'(mag_b);
        exe_next.den      = {mag_b, 1'b0};
        exe_next.prod_lo  = prod[PB-1:0];
        exe_next.prod_neg = prod[2*W-1];
        exe_next.less     = head.less;
        exe_next.equal    = head.equal;
        exe_next.greater  = head.greater;
        unique case (head.operation)
            fpa_pkg::OP_ADD:      exe_next.res = head.operand_a + head.operand_b;
            fpa_pkg::OP_SUB:      exe_next.res = head.operand_a - head.operand_b;
            fpa_pkg::OP_MIN:      exe_next.res = head.less ? head.operand_a : head.operand_b;
            fpa_pkg::OP_MAX:      exe_next.res = head.greater ? head.operand_a : head.operand_b;
            fpa_pkg::OP_INC:      exe_next.res = head.operand_a + W'(1);
            fpa_pkg::OP_DEC:      exe_next.res = head.operand_a - W'(1);
            fpa_pkg::OP_TO_INT:   exe_next.res = head.operand_a >>> F;
            fpa_pkg::OP_FROM_INT: exe_next.res = head.operand_a << F;
            default:              exe_next.res = '0;
        endcase
    end

    // The first divider step also rounds the product half away from zero.
    always_comb
    begin
        pmag    = exe_reg.prod_neg ? PB'(0) - exe_reg.prod_lo : exe_reg.prod_lo;
        pround  = pmag + (PB'(1) << (F - 1));
        mul_mag = pround[PB-1:F];
        first.is_div  = exe_reg.is_div;
        first.neg     = exe_reg.neg;
        first.dz      = exe_reg.dz;
        first.rem     = '0;
        first.num     = exe_reg.num;
        first.den     = exe_reg.den;
        first.quo     = '0;
        first.res     = exe_reg.is_mul
                      ? (exe_reg.prod_neg ? W'(0) - mul_mag : mul_mag) : exe_reg.res;
        first.less    = exe_reg.less;
        first.equal   = exe_reg.equal;
        first.greater = exe_reg.greater;
        for (int k = 0; k < NS; k++)
        begin
            stage_next[k] = div_step(k == 0 ? first : stage_reg[(k == 0) ? 0 : k - 1]);
        end
    end

    always_comb
    begin
        out_next.a_less_b       = stage_reg[NS-1].less;
        out_next.a_equal_b      = stage_reg[NS-1].equal;
        out_next.a_greater_b    = stage_reg[NS-1].greater;
        out_next.divide_by_zero = stage_reg[NS-1].dz;
        priority if (stage_reg[NS-1].dz)
        begin
            out_next.result_value = '0;
        end
        else if (stage_reg[NS-1].is_div)
        begin
            out_next.result_value = stage_reg[NS-1].neg
                                  ? W'(0) - stage_reg[NS-1].quo : stage_reg[NS-1].quo;
        end
        else
        begin
            out_next.result_value = stage_reg[NS-1].res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exe_valid_reg <= 1'b0;
            svalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            exe_valid_reg <= head_valid;
            svalid_reg    <= {svalid_reg[NS-2:0], exe_valid_reg};
            out_valid_reg <= svalid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            exe_reg <= exe_next;
            for (int k = 0; k < NS; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
            out_reg <= out_next;
        end
    end

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.divide_by_zero) |-> (out_reg.result_value == '0))
        else $error("divide by zero with nonzero result");
    a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot({out_reg.a_less_b, out_reg.a_equal_b, out_reg.a_greater_b}))
        else $error("result compare flags not one-hot");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result changed");
    a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |-> !head_pop)
        else $error("queue drained while pipeline stalled");

endmodule

`default_nettype wire
